[rtl/core/mode_inherited_variable_store_unit_assert.svh]
// Assertion macros used by the checker module of the variable store.
`ifndef MODE_INHERITED_VARIABLE_STORE_UNIT_ASSERT_SVH
`define MODE_INHERITED_VARIABLE_STORE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on i_clk and off while i_rst_n is low.
`define MIVS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mivs assertion failed");

// Next-cycle implication, sampled on i_clk and off while i_rst_n is low.
`define MIVS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mivs assertion failed");

`endif

[rtl/core/mivs_pkg.sv]
// Package with the constants, types and helper functions of the variable store.
package mivs_pkg;

    localparam int NUM_MODES   = 9;
    localparam int NUM_GVARS   = 12;
    localparam int PLAIN_GVARS = 7;

    localparam int MODE_W  = $clog2(NUM_MODES);
    localparam int STEP_W  = $clog2(NUM_MODES);
    localparam int DEPTH   = NUM_MODES * NUM_GVARS;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PIDX_W  = (PLAIN_GVARS > 1) ? $clog2(PLAIN_GVARS) : 1;
    localparam int VAL_W   = 12;
    localparam int WORD_W  = 16;
    localparam int RMODE_W = 4;
    localparam int IDX_W   = 4;

    localparam int IN_W  = 32;
    localparam int OUT_W = 24;
    localparam int CFG_W = 12;

    localparam logic [1:0] ACT_READ   = 2'd0;
    localparam logic [1:0] ACT_SCALED = 2'd1;
    localparam logic [1:0] ACT_WRITE  = 2'd2;
    localparam logic [1:0] ACT_INIT   = 2'd3;

    localparam logic [1:0] CFG_MULTI_MODE = 2'd0;
    localparam logic [1:0] CFG_GVAR_MAX   = 2'd1;
    localparam logic [1:0] CFG_PRECISION  = 2'd2;

    localparam logic [10:0] GVAR_MAX_RESET = 11'd1024;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_CHECK,
        ST_DONE
    } t_state;

    function automatic logic [ADDR_W-1:0] f_addr(input logic [MODE_W-1:0] fm,
                                                 input logic [IDX_W-1:0] idx);
        return ADDR_W'(fm) * ADDR_W'(NUM_GVARS) + ADDR_W'(idx);
    endfunction

    function automatic logic [WORD_W-1:0] f_finish(input logic [WORD_W-1:0] raw,
                                                   input logic scale,
                                                   input logic neg);
        logic [WORD_W-1:0] s;
        s = scale ? ((raw << 3) + (raw << 1)) : raw;
        return neg ? (WORD_W'(0) - s) : s;
    endfunction

endpackage

[rtl/core/mivs_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module mivs_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 108,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/mode_inherited_variable_store_unit.sv]
// Top level of the mode-inherited variable store with its resolve sequencer.
// Init, plain-table and index-error items go straight to the result state; a per-mode access
// first walks the inheritance chain, reading one stored entry per link.
// One item at a time: each link passes through the FETCH state (RAM read) and the CHECK state (compare/subtract).
// Reset is synchronous, active low; it restores the control and configuration registers and clears all valid bits.
module mode_inherited_variable_store_unit import mivs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    // action[1:0], gvar_ref[6:2], mode[10:7], write_value[26:11], zero fill.
    input  logic [IN_W-1:0]  i_s_tdata,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    // read_value[15:0], resolved_mode[19:16], index_ok[20], zero fill.
    output logic [OUT_W-1:0] o_m_tdata,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);

    t_state              r_state, n_state;
    logic                r_mme;
    logic [10:0]         r_gvar_max;
    logic [11:0]         r_prec;
    logic [VAL_W-1:0]    r_init_link, n_init_link;
    logic [DEPTH-1:0]    r_valid, n_valid;
    logic [WORD_W-1:0]   r_plain [PLAIN_GVARS];
    logic [WORD_W-1:0]   n_plain [PLAIN_GVARS];
    logic [1:0]          r_action, n_action;
    logic                r_neg, n_neg;
    logic                r_scale, n_scale;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [VAL_W-1:0]    r_wv, n_wv;
    logic [MODE_W-1:0]   r_fm, n_fm;
    logic [STEP_W-1:0]   r_step, n_step;
    logic                r_ok, n_ok;
    logic [RMODE_W-1:0]  r_rmode, n_rmode;
    logic [WORD_W-1:0]   r_res, n_res;
    logic                r_out_valid, n_out_valid;
    logic [OUT_W-1:0]    r_out_data, n_out_data;

    logic                ram_we;
    logic [ADDR_W-1:0]   cur_addr;
    logic [VAL_W-1:0]    ram_rdata;
    logic [VAL_W-1:0]    val;
    logic                is_real;
    logic [12:0]         diff;
    logic [11:0]         nxt;
    logic [1:0]          in_action;
    logic [4:0]          in_ref;
    logic [3:0]          in_mode;
    logic [WORD_W-1:0]   in_wv;
    logic                in_neg;
    logic [IDX_W-1:0]    in_idx;
    logic [WORD_W-1:0]   prec_ext;

    assign cur_addr  = f_addr(r_fm, r_idx);
    assign in_action = i_s_tdata[1:0];
    assign in_ref    = i_s_tdata[6:2];
    assign in_mode   = i_s_tdata[10:7];
    assign in_wv     = i_s_tdata[26:11];
    assign in_neg    = in_ref[4];
    assign in_idx    = in_neg ? ~in_ref[3:0] : in_ref[3:0];
    assign prec_ext  = WORD_W'(r_prec);

    mivs_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (cur_addr),
        .i_wdata (r_wv),
        .i_raddr (cur_addr),
        .o_rdata (ram_rdata)
    );

    assign val     = r_valid[cur_addr] ? ram_rdata
                   : ((r_fm == '0) ? VAL_W'(0) : r_init_link);
    assign is_real = $signed({val[11], val}) <= $signed({2'b00, r_gvar_max});
    assign diff    = {val[11], val} - {2'b00, r_gvar_max} - 13'd1;

    always_comb begin
        nxt = {1'b0, diff[10:0]};
        if (nxt >= 12'(r_fm)) begin
            nxt = nxt + 12'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mme      <= 1'b0;
            r_gvar_max <= GVAR_MAX_RESET;
            r_prec     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MULTI_MODE: r_mme      <= i_cfg_data[0];
                CFG_GVAR_MAX:   r_gvar_max <= i_cfg_data[10:0];
                CFG_PRECISION:  r_prec     <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
            r_plain     <= '{default: '0};
            r_init_link <= 12'({1'b0, GVAR_MAX_RESET} + 12'd1);
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_valid     <= n_valid;
            r_plain     <= n_plain;
            r_init_link <= n_init_link;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action   <= n_action;
        r_neg      <= n_neg;
        r_scale    <= n_scale;
        r_idx      <= n_idx;
        r_wv       <= n_wv;
        r_fm       <= n_fm;
        r_step     <= n_step;
        r_ok       <= n_ok;
        r_rmode    <= n_rmode;
        r_res      <= n_res;
        r_out_data <= n_out_data;
    end

    always_comb begin
        n_state     = r_state;
        n_valid     = r_valid;
        n_plain     = r_plain;
        n_init_link = r_init_link;
        n_action    = r_action;
        n_neg       = r_neg;
        n_scale     = r_scale;
        n_idx       = r_idx;
        n_wv        = r_wv;
        n_fm        = r_fm;
        n_step      = r_step;
        n_ok        = r_ok;
        n_rmode     = r_rmode;
        n_res       = r_res;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_data  = r_out_data;
        ram_we      = 1'b0;
        o_s_tready  = 1'b0;

        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    n_action = in_action;
                    n_neg    = in_neg;
                    n_idx    = in_idx;
                    n_wv     = in_wv[VAL_W-1:0];
                    n_scale  = (in_action == ACT_SCALED) && !prec_ext[in_idx];
                    n_ok     = 1'b1;
                    n_rmode  = '0;
                    n_res    = '0;
                    n_fm     = '0;
                    n_step   = '0;
                    n_state  = ST_DONE;
                    case (in_action)
                        ACT_INIT: begin
                            n_valid     = '0;
                            n_plain     = '{default: '0};
                            n_init_link = 12'({1'b0, r_gvar_max} + 12'd1);
                        end
                        ACT_WRITE: begin
                            if (in_neg) begin
                                n_ok = 1'b0;
                            end else if (!r_mme) begin
                                if ({1'b0, in_idx} < 5'(PLAIN_GVARS)) begin
                                    n_plain[in_idx[PIDX_W-1:0]] = in_wv;
                                end else begin
                                    n_ok = 1'b0;
                                end
                            end else if ({1'b0, in_idx} < 5'(NUM_GVARS)) begin
                                n_state = ST_FETCH;
                            end else begin
                                n_ok = 1'b0;
                            end
                        end
                        default: begin
                            if (!r_mme) begin
                                if ({1'b0, in_idx} < 5'(PLAIN_GVARS)) begin
                                    n_res = f_finish(r_plain[in_idx[PIDX_W-1:0]],
                                                     n_scale, in_neg);
                                end else begin
                                    n_ok = 1'b0;
                                end
                            end else if ({1'b0, in_idx} < 5'(NUM_GVARS)) begin
                                n_state = ST_FETCH;
                            end else begin
                                n_ok = 1'b0;
                            end
                        end
                    endcase
                    if (n_state == ST_FETCH) begin
                        if ({1'b0, in_mode} >= 5'(NUM_MODES)) begin
                            n_ok = 1'b0;
                        end else begin
                            n_fm = in_mode[MODE_W-1:0];
                        end
                    end
                end
            end
            ST_FETCH: begin
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                n_state = ST_FETCH;
                if (r_fm == '0 || is_real) begin
                    n_rmode = RMODE_W'(r_fm);
                    n_state = ST_DONE;
                    if (r_action == ACT_WRITE) begin
                        ram_we            = 1'b1;
                        n_valid[cur_addr] = 1'b1;
                    end else begin
                        n_res = f_finish({{(WORD_W-VAL_W){val[VAL_W-1]}}, val},
                                         r_scale, r_neg);
                    end
                end else if (nxt >= 12'(NUM_MODES)) begin
                    n_fm = '0;
                    n_ok = 1'b0;
                end else if (r_step == STEP_W'(NUM_MODES - 1)) begin
                    n_fm = '0;
                end else begin
                    n_fm   = nxt[MODE_W-1:0];
                    n_step = r_step + STEP_W'(1);
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {3'b000, r_ok, r_rmode, r_res};
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

[rtl/core/mivs_checker.sv]
// Port-level checker for the variable store and its bind to the top level.
`include "mode_inherited_variable_store_unit_assert.svh"

module mivs_checker import mivs_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_s_tvalid,
    input logic             o_s_tready,
    input logic             o_m_tvalid,
    input logic             i_m_tready,
    input logic [OUT_W-1:0] o_m_tdata
);

    `MIVS_ASSERT_NEXT(a_busy_after_accept, i_s_tvalid && o_s_tready, !o_s_tready)
    `MIVS_ASSERT_NEXT(a_stall_holds, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata))
    `MIVS_ASSERT_IMPL(a_error_mode_zero, o_m_tvalid && !o_m_tdata[20], o_m_tdata[19:16] == 4'd0)
    `MIVS_ASSERT_IMPL(a_mode_in_range, o_m_tvalid, {1'b0, o_m_tdata[19:16]} < 5'(NUM_MODES))

endmodule

bind mode_inherited_variable_store_unit mivs_checker u_mivs_checker (.*);

[verif/mode_inherited_variable_store_unit_tb.sv]
// Self-checking testbench for the mode-inherited variable store with its own predictor.
`timescale 1ns / 1ps

module mode_inherited_variable_store_unit_tb;
    import mivs_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int END_CYCLES  = 40;

    typedef struct packed {
        logic [1:0]  action;
        logic [4:0]  gref;
        logic [3:0]  mode;
        logic [15:0] wv;
    } store_item_t;

    typedef struct packed {
        logic [15:0] value;
        logic [3:0]  rmode;
        logic        ok;
    } store_result_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic             cfg_we = 1'b0;
    logic [1:0]       cfg_idx = CFG_MULTI_MODE;
    logic [CFG_W-1:0] cfg_data = '0;

    logic        multi_q;
    logic [10:0] gmax_q;
    logic [11:0] prec_q;
    logic [11:0] mode_store [NUM_MODES][NUM_GVARS];
    logic [15:0] plain_store [PLAIN_GVARS];

    store_result_t pending_results[$];
    int  error_count = 0;
    int  cycle_count = 0;
    bit  tx_idle_on = 1'b1;
    bit  rx_idle_on = 1'b1;
    int  rx_long_hold = 0;
    int  rx_burst_left = 0;

    mode_inherited_variable_store_unit u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #1 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("mode_inherited_variable_store_unit_tb: done, errors");
            $finish;
        end
    end

    // The receiver stalls in short random bursts, or for one long stretch on request.
    always @(posedge clk) begin
        if (rx_burst_left > 0) begin
            m_tready <= 1'b0;
            rx_burst_left <= rx_burst_left - 1;
        end else if (rx_long_hold > 0) begin
            m_tready <= 1'b0;
            rx_long_hold <= rx_long_hold - 1;
        end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
            m_tready <= 1'b0;
            rx_burst_left <= $urandom_range(0, 10);
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic report_error(input string msg);
        $display("ERROR at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    always @(posedge clk) begin : result_check
        store_result_t want;
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_error($sformatf("result beat %h with nothing expected", m_tdata));
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[15:0] !== want.value)
                    report_error($sformatf("read_value got %0d expected %0d",
                                           $signed(m_tdata[15:0]), $signed(want.value)));
                if (m_tdata[19:16] !== want.rmode)
                    report_error($sformatf("resolved_mode got %0d expected %0d",
                                           m_tdata[19:16], want.rmode));
                if (m_tdata[20] !== want.ok)
                    report_error($sformatf("index_ok got %b expected %b",
                                           m_tdata[20], want.ok));
            end
        end
    end

    function automatic void clear_store();
        logic [11:0] link;
        link = 12'(gmax_q + 1);
        for (int m = 0; m < NUM_MODES; m++)
            for (int g = 0; g < NUM_GVARS; g++)
                mode_store[m][g] = (m == 0) ? 12'd0 : link;
        for (int p = 0; p < PLAIN_GVARS; p++)
            plain_store[p] = 16'd0;
    endfunction

    function automatic int follow_chain(input int start, input int idx, inout bit ok);
        int fm;
        int val;
        int nxt;
        fm = start;
        if (fm >= NUM_MODES) begin
            ok = 1'b0;
            return 0;
        end
        for (int step = 0; step < NUM_MODES; step++) begin
            if (fm == 0)
                return 0;
            val = $signed(mode_store[fm][idx]);
            if (val <= int'(gmax_q))
                return fm;
            nxt = val - int'(gmax_q) - 1;
            if (nxt >= fm)
                nxt++;
            if (nxt >= NUM_MODES) begin
                ok = 1'b0;
                return 0;
            end
            fm = nxt;
        end
        return 0;
    endfunction

    function automatic store_result_t predict_access(input store_item_t it);
        store_result_t r;
        bit          neg;
        bit          ok;
        bit          got;
        bit          scale;
        int          idx;
        int          fm;
        logic [15:0] raw;
        r     = '0;
        ok    = 1'b1;
        got   = 1'b0;
        fm    = 0;
        raw   = '0;
        neg   = it.gref[4];
        idx   = it.gref;
        if (neg)
            idx = 31 - idx;
        case (it.action)
            ACT_INIT: begin
                clear_store();
            end
            ACT_WRITE: begin
                if (neg) begin
                    ok = 1'b0;
                end else if (!multi_q) begin
                    if (idx < PLAIN_GVARS)
                        plain_store[idx] = it.wv;
                    else
                        ok = 1'b0;
                end else if (idx < NUM_GVARS) begin
                    fm = follow_chain(it.mode, idx, ok);
                    mode_store[fm][idx] = it.wv[11:0];
                end else begin
                    ok = 1'b0;
                end
            end
            default: begin
                scale = (it.action == ACT_SCALED) && !(idx < 12 && prec_q[idx]);
                if (!multi_q) begin
                    if (idx < PLAIN_GVARS) begin
                        raw = plain_store[idx];
                        got = 1'b1;
                    end else begin
                        ok = 1'b0;
                    end
                end else if (idx < NUM_GVARS) begin
                    fm  = follow_chain(it.mode, idx, ok);
                    raw = {{4{mode_store[fm][idx][11]}}, mode_store[fm][idx]};
                    got = 1'b1;
                end else begin
                    ok = 1'b0;
                end
                if (got) begin
                    if (scale)
                        raw = raw * 16'd10;
                    if (neg)
                        raw = 16'd0 - raw;
                    r.value = raw;
                end
            end
        endcase
        r.rmode = 4'(fm);
        r.ok    = ok;
        return r;
    endfunction

    task automatic send_access(input logic [1:0] action, input logic [4:0] gref,
                               input logic [3:0] mode, input logic [15:0] wv);
        store_item_t it;
        it = '{action: action, gref: gref, mode: mode, wv: wv};
        if (tx_idle_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, it.wv, it.mode, it.gref, it.action};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        pending_results.push_back(predict_access(it));
    endtask

    task automatic program_regs(input logic multi, input logic [10:0] gmax,
                                input logic [11:0] prec);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_MULTI_MODE;
        cfg_data <= {11'd0, multi};
        @(posedge clk);
        cfg_idx  <= CFG_GVAR_MAX;
        cfg_data <= {1'b0, gmax};
        @(posedge clk);
        cfg_idx  <= CFG_PRECISION;
        cfg_data <= prec;
        @(posedge clk);
        cfg_we  <= 1'b0;
        multi_q = multi;
        gmax_q  = gmax;
        prec_q  = prec;
    endtask

    // In multi-mode operation, writes mostly carry real values or link encodings relative to link_base.
    function automatic store_item_t draw_access(input int link_base);
        store_item_t it;
        int pick;
        int v;
        int span;
        span = multi_q ? NUM_GVARS : PLAIN_GVARS;
        pick = $urandom_range(0, 99);
        if (pick < 2)
            it.action = ACT_INIT;
        else if (pick < 40)
            it.action = ACT_WRITE;
        else if (pick < 60)
            it.action = ACT_SCALED;
        else
            it.action = ACT_READ;
        it.gref = 5'($urandom_range(0, span - 1));
        if (it.action != ACT_WRITE && $urandom_range(0, 3) == 0)
            it.gref = 5'd31 - it.gref;
        if ($urandom_range(0, 9) == 0)
            it.gref = 5'($urandom());
        it.mode = 4'($urandom_range(0, NUM_MODES - 1));
        if ($urandom_range(0, 9) == 0)
            it.mode = 4'($urandom());
        pick = $urandom_range(0, 9);
        if (!multi_q || pick == 9)
            v = $urandom();
        else if (pick < 5)
            v = link_base + 1 + $urandom_range(0, NUM_MODES);
        else
            v = int'($urandom_range(0, link_base + 2048)) - 2048;
        it.wv = multi_q ? {4'($urandom()), 12'(v)} : 16'(v);
        return it;
    endfunction

    task automatic run_access_burst(input int count, input int link_base);
        store_item_t it;
        for (int n = 0; n < count; n++) begin
            it = draw_access(link_base);
            send_access(it.action, it.gref, it.mode, it.wv);
        end
    endtask

    task automatic test_plain_table();
        send_access(ACT_WRITE,  5'd0,  4'd0,  16'h7FFF);
        send_access(ACT_WRITE,  5'd6,  4'd3,  16'h8000);
        send_access(ACT_WRITE,  5'd7,  4'd0,  16'h1234);
        send_access(ACT_WRITE,  5'h1F, 4'd0,  16'hFFFF);
        send_access(ACT_READ,   5'd0,  4'd15, 16'h0000);
        send_access(ACT_SCALED, 5'd0,  4'd0,  16'h0000);
        send_access(ACT_READ,   5'h19, 4'd0,  16'h0000);
        send_access(ACT_SCALED, 5'h10, 4'd0,  16'h0000);
        send_access(ACT_READ,   5'd15, 4'd0,  16'h0000);
    endtask

    task automatic test_mode_inheritance();
        program_regs(1'b1, GVAR_MAX_RESET, 12'h000);
        send_access(ACT_READ,   5'd2,  4'd3,  16'h0000);
        send_access(ACT_READ,   5'd2,  4'd15, 16'h0000);
        send_access(ACT_WRITE,  5'd0,  4'd12, 16'hF7FF);
        send_access(ACT_SCALED, 5'h1F, 4'd4,  16'h0000);
        // With the largest threshold every stored entry is a real value, so each mode keeps
        // its own writes; all but the write to mode 5 become links once the threshold drops to 100.
        program_regs(1'b1, 11'd2047, 12'hFFF);
        send_access(ACT_WRITE,  5'd1,  4'd1,  16'd102);
        send_access(ACT_WRITE,  5'd1,  4'd2,  16'd102);
        send_access(ACT_WRITE,  5'd1,  4'd3,  16'd121);
        send_access(ACT_WRITE,  5'd1,  4'd4,  16'd101);
        send_access(ACT_WRITE,  5'd1,  4'd5,  16'h0800);
        program_regs(1'b1, 11'd100, 12'h001);
        send_access(ACT_READ,   5'd1,  4'd1,  16'h0000);
        send_access(ACT_READ,   5'd1,  4'd3,  16'h0000);
        send_access(ACT_SCALED, 5'd1,  4'd4,  16'h0000);
        send_access(ACT_SCALED, 5'h1E, 4'd5,  16'h0000);
        send_access(ACT_WRITE,  5'd1,  4'd3,  16'h0033);
        send_access(ACT_READ,   5'd12, 4'd2,  16'h0000);
        send_access(ACT_READ,   5'h13, 4'd2,  16'h0000);
        send_access(ACT_INIT,   5'd0,  4'd0,  16'h0000);
        send_access(ACT_READ,   5'd1,  4'd5,  16'h0000);
        program_regs(1'b1, 11'd2047, 12'h000);
        send_access(ACT_INIT,   5'd0,  4'd0,  16'h0000);
        send_access(ACT_SCALED, 5'h17, 4'd8,  16'h0000);
    endtask

    task automatic test_random_mix();
        program_regs(1'b0, GVAR_MAX_RESET, 12'($urandom()));
        run_access_burst(120, 1024);
        program_regs(1'b1, GVAR_MAX_RESET, 12'h000);
        run_access_burst(80, 1024);
        program_regs(1'b1, 11'd2047, 12'hFFF);
        run_access_burst(100, 600);
        program_regs(1'b1, 11'd600, 12'($urandom()));
        run_access_burst(130, 600);
        program_regs(1'b1, 11'd0, 12'($urandom()));
        run_access_burst(80, 0);
        program_regs(1'b1, 11'd2047, 12'($urandom()));
        run_access_burst(80, 1500);
        program_regs(1'b1, 11'd1500, 12'($urandom()));
        run_access_burst(100, 1500);
        program_regs(1'b1, 11'd2000, 12'($urandom()));
        run_access_burst(60, 2000);
    endtask

    // The sink holds off long enough for the block to fill and stall its input.
    task automatic test_sink_holdoff();
        program_regs(1'b1, 11'd600, 12'($urandom()));
        rx_long_hold = 300;
        run_access_burst(30, 600);
    endtask

    task automatic test_full_rate();
        int base;
        base = $urandom_range(0, 2000);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        program_regs(1'b1, 11'd2047, 12'($urandom()));
        run_access_burst(50, base);
        program_regs(1'b1, 11'(base), 12'($urandom()));
        run_access_burst(100, base);
        program_regs(1'b0, 11'(base), 12'($urandom()));
        run_access_burst(40, base);
    endtask

    initial begin
        multi_q = 1'b0;
        gmax_q  = GVAR_MAX_RESET;
        prec_q  = 12'h000;
        clear_store();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_plain_table();
        test_mode_inheritance();
        test_random_mix();
        test_sink_holdoff();
        test_full_rate();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (END_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("mode_inherited_variable_store_unit_tb: done, clean");
        else
            $display("mode_inherited_variable_store_unit_tb: done, errors");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/mivs_pkg.sv
rtl/core/mivs_ram.sv
rtl/core/mode_inherited_variable_store_unit.sv
rtl/core/mivs_checker.sv
verif/mode_inherited_variable_store_unit_tb.sv
